/* rtl/rbd_pkg.sv */
`timescale 1ns / 1ps
package rbd_pkg;

  localparam int MAX_SOURCE_WIDTH_DEF  = 512;
  localparam int MAX_SOURCE_HEIGHT_DEF = 1024;
  localparam int FRACTION_BITS_DEF     = 16;

  localparam int PIXEL_W     = 24;
  localparam int COL_COORD_W = 26;
  localparam int ROW_COORD_W = 27;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 26;
  localparam int TARGET_LIMIT = 512;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_STEP   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_STEP      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_OUTPUT = 3'd6;

  localparam logic [9:0]  SOURCE_WIDTH_RST  = 10'd480;
  localparam logic [10:0] SOURCE_HEIGHT_RST = 11'd320;
  localparam logic [9:0]  TARGET_WIDTH_RST  = 10'd100;
  localparam logic [9:0]  TARGET_HEIGHT_RST = 10'd100;
  localparam logic [24:0] COLUMN_STEP_RST   = 25'd313917;
  localparam logic [25:0] ROW_STEP_RST      = 26'd209059;

  localparam logic [7:0] SIGNED_OFFSET = 8'd127;

  typedef struct packed {
    logic [15:0] source_pixel;
    logic        frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] out_column;
    logic [8:0] out_row;
    logic       frame_done;
  } out_item_t;

  // RGB565 to RGB888 by replicating the top bits into the low bits.
  function automatic logic [PIXEL_W-1:0] widen(input logic [15:0] w);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = w[15:11];
    g6 = w[10:5];
    b5 = w[4:0];
    return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
  endfunction

endpackage

/* rtl/rbd_ram.sv */
`timescale 1ns / 1ps
module rbd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write to the same address return the old word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/rgb565_bilinear_downscaler_unit.sv */
`timescale 1ns / 1ps
// Streaming bilinear downscaler: RGB565 source pixels in raster order on the
// input channel (in_valid / in_stall / in_item), RGB888 pixels of the smaller
// frame in raster order on the output channel (out_valid / out_stall /
// out_item). An item carrying frame_start marks source position (0,0).
// Each source pixel causes zero or one output item.
// Configuration is written through cfg_write / cfg_index / cfg_data while the
// block is idle; the user must keep to this, as the block does not enforce it.
// A write takes effect at the clock edge. An input item that produces no output
// passes through the accept and the line buffer read; one that does produce an
// output also makes 18 passes through the single shared multiply-accumulate
// unit (six per color channel) and then loads the output register. in_stall is
// high for all but the accept cycle. The output register holds a finished item
// while out_stall is high and the block may already take the next input
// meanwhile; a new result waits for the register to empty.
// Reset (rst, synchronous) restores the default sizes and steps and clears all
// position counters and output valid; the line buffer is not cleared.
module rgb565_bilinear_downscaler_unit #(
  parameter int MAX_SOURCE_WIDTH  = rbd_pkg::MAX_SOURCE_WIDTH_DEF,
  parameter int MAX_SOURCE_HEIGHT = rbd_pkg::MAX_SOURCE_HEIGHT_DEF,
  parameter int FRACTION_BITS     = rbd_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rbd_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rbd_pkg::out_item_t                  out_item,
  input  logic                                cfg_write,
  input  logic [rbd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rbd_pkg::*;

  localparam int CW = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
  localparam int RW = (MAX_SOURCE_HEIGHT > 1) ? $clog2(MAX_SOURCE_HEIGHT) : 1;
  localparam int F  = FRACTION_BITS;
  localparam int MA = F + 9;       // multiplier data operand
  localparam int MB = F + 1;       // multiplier weight operand
  localparam int AW = 2 * F + 9;   // accumulator

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CALC = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [9:0]  source_width;
  logic [10:0] source_height;
  logic [9:0]  target_width;
  logic [9:0]  target_height;
  logic [24:0] column_step;
  logic [25:0] row_step;
  logic        signed_output;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SOURCE_WIDTH_RST;
      source_height <= SOURCE_HEIGHT_RST;
      target_width  <= TARGET_WIDTH_RST;
      target_height <= TARGET_HEIGHT_RST;
      column_step   <= COLUMN_STEP_RST;
      row_step      <= ROW_STEP_RST;
      signed_output <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[9:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[10:0];
        REG_TARGET_WIDTH:  target_width  <= cfg_data[9:0];
        REG_TARGET_HEIGHT: target_height <= cfg_data[9:0];
        REG_COLUMN_STEP:   column_step   <= cfg_data[24:0];
        REG_ROW_STEP:      row_step      <= cfg_data[25:0];
        REG_SIGNED_OUTPUT: signed_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Position state.
  logic [CW-1:0]          source_column;
  logic [RW-1:0]          source_row;
  logic [8:0]             target_column;
  logic [8:0]             target_row;
  logic [COL_COORD_W-1:0] column_coord;
  logic [ROW_COORD_W-1:0] row_coord;
  logic [PIXEL_W-1:0]     left_pixel;
  logic [PIXEL_W-1:0]     upper_left_pixel;

  // Clamped sizes.
  logic [CW:0] w_c;
  logic [RW:0] h_c;
  logic [9:0]  tw_c;
  logic [9:0]  th_c;

  always_comb begin
    if (32'(source_width) < 32'd2) begin
      w_c = (CW+1)'(2);
    end else if (32'(source_width) > 32'(MAX_SOURCE_WIDTH)) begin
      w_c = (CW+1)'(MAX_SOURCE_WIDTH);
    end else begin
      w_c = (CW+1)'(source_width);
    end
    if (32'(source_height) < 32'd2) begin
      h_c = (RW+1)'(2);
    end else if (32'(source_height) > 32'(MAX_SOURCE_HEIGHT)) begin
      h_c = (RW+1)'(MAX_SOURCE_HEIGHT);
    end else begin
      h_c = (RW+1)'(source_height);
    end
    if (target_width == 10'd0) begin
      tw_c = 10'd1;
    end else if (32'(target_width) > 32'(TARGET_LIMIT)) begin
      tw_c = 10'(TARGET_LIMIT);
    end else begin
      tw_c = target_width;
    end
    if (target_height == 10'd0) begin
      th_c = 10'd1;
    end else if (32'(target_height) > 32'(TARGET_LIMIT)) begin
      th_c = 10'(TARGET_LIMIT);
    end else begin
      th_c = target_height;
    end
  end

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  // Accept-cycle position and sample arithmetic.
  logic [PIXEL_W-1:0]     pix;
  logic [CW:0]            sc_a;
  logic [RW:0]            sr_a;
  logic [CW-1:0]          sc;
  logic [RW-1:0]          sr;
  logic                   restart;
  logic [8:0]             tc_e;
  logic [8:0]             tr_e;
  logic [COL_COORD_W-1:0] cc_e;
  logic [ROW_COORD_W-1:0] rc_e;
  logic [CW-1:0]          w_m1;
  logic [RW-1:0]          h_m1;
  logic [CW-1:0]          x1;
  logic [CW-1:0]          x2;
  logic [RW-1:0]          y1;
  logic [RW-1:0]          y2;
  logic                   hit;
  logic                   col_last;
  logic                   row_last;
  logic [COL_COORD_W:0]   cc_sum;
  logic [ROW_COORD_W:0]   rc_sum;
  logic [CW:0]            sc_inc;
  logic [RW:0]            sr_inc;
  logic [CW-1:0]          sc_next;
  logic [RW-1:0]          sr_next;

  always_comb begin
    pix = widen(in_item.source_pixel);
    sc_a = {1'b0, source_column};
    sr_a = {1'b0, source_row};
    if (in_item.frame_start) begin
      sc_a = '0;
      sr_a = '0;
    end
    if (sc_a >= w_c) begin
      sc_a = '0;
      sr_a = sr_a + 1'b1;
    end
    if (sr_a >= h_c) begin
      sr_a = '0;
    end
    sc = sc_a[CW-1:0];
    sr = sr_a[RW-1:0];
    restart = (sc == '0) && (sr == '0);
    tc_e = restart ? '0 : target_column;
    tr_e = restart ? '0 : target_row;
    cc_e = restart ? '0 : column_coord;
    rc_e = restart ? '0 : row_coord;

    w_m1 = CW'(w_c - 1'b1);
    h_m1 = RW'(h_c - 1'b1);
    if (32'(cc_e[COL_COORD_W-1:F]) > 32'(w_m1)) begin
      x1 = w_m1;
    end else begin
      x1 = CW'(cc_e[COL_COORD_W-1:F]);
    end
    if (32'(rc_e[ROW_COORD_W-1:F]) > 32'(h_m1)) begin
      y1 = h_m1;
    end else begin
      y1 = RW'(rc_e[ROW_COORD_W-1:F]);
    end
    x2 = ({1'b0, x1} + 1'b1 > {1'b0, w_m1}) ? w_m1 : CW'({1'b0, x1} + 1'b1);
    y2 = ({1'b0, y1} + 1'b1 > {1'b0, h_m1}) ? h_m1 : RW'({1'b0, y1} + 1'b1);

    hit = (sc == x2) && (sr == y2) && ({1'b0, tc_e} < tw_c) && ({1'b0, tr_e} < th_c);
    col_last = ({1'b0, tc_e} + 10'd1 >= tw_c);
    row_last = ({1'b0, tr_e} + 10'd1 >= th_c);
    cc_sum = {1'b0, cc_e} + (COL_COORD_W+1)'(column_step);
    rc_sum = {1'b0, rc_e} + (ROW_COORD_W+1)'(row_step);

    sc_inc = {1'b0, sc} + 1'b1;
    sr_inc = {1'b0, sr};
    if (sc_inc >= w_c) begin
      sc_inc = '0;
      sr_inc = sr_inc + 1'b1;
      if (sr_inc >= h_c) begin
        sr_inc = '0;
      end
    end
    sc_next = sc_inc[CW-1:0];
    sr_next = sr_inc[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row    <= '0;
      target_column <= '0;
      target_row    <= '0;
      column_coord  <= '0;
      row_coord     <= '0;
    end else if (accept) begin
      source_column <= sc_next;
      source_row    <= sr_next;
      target_column <= tc_e;
      target_row    <= tr_e;
      column_coord  <= cc_e;
      row_coord     <= rc_e;
      if (hit) begin
        if (col_last) begin
          target_column <= '0;
          column_coord  <= '0;
          if (row_last) begin
            target_row <= '0;
            row_coord  <= '0;
          end else begin
            target_row <= tr_e + 1'b1;
            row_coord  <= rc_sum[ROW_COORD_W] ? '1 : rc_sum[ROW_COORD_W-1:0];
          end
        end else begin
          target_column <= tc_e + 1'b1;
          column_coord  <= cc_sum[COL_COORD_W] ? '1 : cc_sum[COL_COORD_W-1:0];
        end
      end
    end
  end

  // Line buffer holding the previous source row.
  logic [PIXEL_W-1:0] up_pix;

  rbd_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_SOURCE_WIDTH)
  ) u_row_store (
    .clk    (clk),
    .wr_en  (accept),
    .wr_addr(sc),
    .wr_data(pix),
    .rd_addr(sc),
    .rd_data(up_pix)
  );

  // Work registers for the item in flight.
  logic [PIXEL_W-1:0] p_w;
  logic [PIXEL_W-1:0] bl_w;
  logic [PIXEL_W-1:0] ul_w;
  logic [PIXEL_W-1:0] tl_w;
  logic [PIXEL_W-1:0] tr_w;
  logic [F-1:0]       fx;
  logic [F-1:0]       fy;
  logic               x_same;
  logic               y_same;
  logic               hit_w;
  logic [8:0]         res_col;
  logic [8:0]         res_row;
  logic               res_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else begin
      if (accept) begin
        left_pixel <= pix;
      end
      if (state == ST_READ) begin
        upper_left_pixel <= up_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_w      <= pix;
      bl_w     <= (x1 == x2) ? pix : left_pixel;
      ul_w     <= upper_left_pixel;
      fx       <= cc_e[F-1:0];
      fy       <= rc_e[F-1:0];
      x_same   <= (x1 == x2);
      y_same   <= (y1 == y2);
      res_col  <= tc_e;
      res_row  <= tr_e;
      res_done <= col_last && row_last;
    end
    if (state == ST_READ) begin
      tr_w <= y_same ? p_w : up_pix;
      tl_w <= y_same ? bl_w : (x_same ? up_pix : ul_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_w <= 1'b0;
    end else if (accept) begin
      hit_w <= hit;
    end
  end

  // Shared multiply-accumulate unit. For each channel the six steps form
  // the two horizontal blends and then the vertical blend of those.
  logic [2:0]    ph;
  logic [1:0]    ch;
  logic [MA-1:0] m_a;
  logic [MB-1:0] m_b;
  logic [AW-1:0] prod;
  logic [AW-1:0] mac_sum;
  logic [AW-1:0] acc;
  logic [MA-1:0] h1;
  logic [MA-1:0] h2;
  logic [MB-1:0] one_fx;
  logic [MB-1:0] one_fy;
  logic [7:0]    b_tl;
  logic [7:0]    b_tr;
  logic [7:0]    b_bl;
  logic [7:0]    b_br;
  logic [7:0]    chan_raw;
  logic [7:0]    chan_val;
  logic [7:0]    red_r;
  logic [7:0]    green_r;
  logic [7:0]    blue_r;
  logic          last_step;

  always_comb begin
    one_fx = {1'b1, {F{1'b0}}} - {1'b0, fx};
    one_fy = {1'b1, {F{1'b0}}} - {1'b0, fy};
    case (ch)
      2'd0: begin
        b_tl = tl_w[23:16]; b_tr = tr_w[23:16]; b_bl = bl_w[23:16]; b_br = p_w[23:16];
      end
      2'd1: begin
        b_tl = tl_w[15:8]; b_tr = tr_w[15:8]; b_bl = bl_w[15:8]; b_br = p_w[15:8];
      end
      default: begin
        b_tl = tl_w[7:0]; b_tr = tr_w[7:0]; b_bl = bl_w[7:0]; b_br = p_w[7:0];
      end
    endcase
    case (ph)
      3'd0: begin m_a = MA'(b_tl); m_b = one_fx;       end
      3'd1: begin m_a = MA'(b_tr); m_b = {1'b0, fx};   end
      3'd2: begin m_a = MA'(b_bl); m_b = one_fx;       end
      3'd3: begin m_a = MA'(b_br); m_b = {1'b0, fx};   end
      3'd4: begin m_a = h1;        m_b = one_fy;       end
      default: begin m_a = h2;     m_b = {1'b0, fy};   end
    endcase
    prod     = AW'(m_a) * AW'(m_b);
    mac_sum  = (ph[0] ? acc : '0) + prod;
    chan_raw = mac_sum[2*F+7:2*F];
    chan_val = signed_output ? chan_raw - SIGNED_OFFSET : chan_raw;
    last_step = (ph == 3'd5) && (ch == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      acc <= mac_sum;
      if (ph == 3'd1) begin
        h1 <= MA'(mac_sum);
      end
      if (ph == 3'd3) begin
        h2 <= MA'(mac_sum);
      end
      if (ph == 3'd5) begin
        case (ch)
          2'd0:    red_r   <= chan_val;
          2'd1:    green_r <= chan_val;
          default: blue_r  <= chan_val;
        endcase
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ph    <= '0;
      ch    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          ph    <= '0;
          ch    <= '0;
          state <= hit_w ? ST_CALC : ST_IDLE;
        end
        ST_CALC: begin
          if (last_step) begin
            state <= ST_DONE;
          end else if (ph == 3'd5) begin
            ph <= '0;
            ch <= ch + 1'b1;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic load_out;
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.red        <= red_r;
      out_item.green      <= green_r;
      out_item.blue       <= blue_r;
      out_item.out_column <= res_col;
      out_item.out_row    <= res_row;
      out_item.frame_done <= res_done;
    end
  end

`ifndef SYNTH
  a_accept_reads : assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_READ)
    else $error("accepted item did not start the line buffer read");

  a_calc_ends : assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) && last_step |=> state == ST_DONE)
    else $error("last multiply step did not finish the item");

  a_chan_range : assert property (@(posedge clk) disable iff (rst)
    state == ST_CALC |-> (ch != 2'd3) && (ph <= 3'd5))
    else $error("step counters out of range");

  a_done_loads : assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && (state == ST_IDLE))
    else $error("finished result not presented");
`endif

endmodule
